>>> design/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion shorthands, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge
`define BTA_ASSERT(name, cond) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define BTA_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define BTA_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> design/bta_pkg.sv
// ---------------------------------------------------------------------------
// bta_pkg
// shared constants, types and helpers of the boundary tag heap allocator
// ---------------------------------------------------------------------------
package bta_pkg;

	localparam int HEAP_BYTES  = 4096;
	localparam int DATA_BYTES  = HEAP_BYTES - (HEAP_BYTES % 8);
	localparam int TOTAL_BYTES = DATA_BYTES + 16;
	localparam int DEPTH       = TOTAL_BYTES / 4;
	localparam int AW          = $clog2(DEPTH);

	localparam int REQW = 13;
	localparam int OFFW = 13;

	// tag word: size in bytes (multiple of 8) with the allocated flag in bit 0
	localparam int SW0 = $clog2(DATA_BYTES + 1);
	localparam int SW  = (SW0 > REQW + 1) ? SW0 : REQW + 1;

	// byte address width, with headroom for p + 16 + size
	localparam int BW0 = $clog2(TOTAL_BYTES + 64);
	localparam int BW  = (BW0 > SW) ? BW0 : SW;

	localparam logic KIND_ALLOC = 1'b0;
	localparam logic KIND_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANT = 2'd0,
		ST_NOFIT = 2'd1,
		ST_FREED = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_INIT0,
		S_INIT1,
		S_IDLE,
		S_READ,
		S_EVAL,
		S_READQ,
		S_EVALQ,
		S_MERGE,
		S_WRITE
	} state_t;

	typedef struct packed {
		logic          we;
		logic [AW-1:0] addr;
		logic [SW-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic            valid;
		status_t         status;
		logic [OFFW-1:0] offset;
	} result_t;

	function automatic logic [AW-1:0] word_idx(input logic [BW-1:0] b);
		return b[AW+1:2];
	endfunction

endpackage

>>> design/bta_ram.sv
// ---------------------------------------------------------------------------
// bta_ram
// single port synchronous ram, read first, registered read data
// ---------------------------------------------------------------------------
module bta_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> design/bta_engine.sv
// ---------------------------------------------------------------------------
// bta_engine
// sequencer that walks the tag chain, decides and writes the tags back
// ---------------------------------------------------------------------------
module bta_engine (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     kind,
	input  logic [bta_pkg::REQW-1:0] request_bytes,
	input  logic [bta_pkg::OFFW-1:0] block_offset,
	output logic                     busy,
	output bta_pkg::mem_req_t        mem_req,
	input  logic [bta_pkg::SW-1:0]   rd_data,
	output bta_pkg::result_t         res
);
	import bta_pkg::*;

	state_t state_q, state_d;

	logic            kind_q;
	logic [SW-1:0]   size_q;
	logic [OFFW-1:0] off_q;
	logic [BW-1:0]   p_q;

	logic            have_prev_q;
	logic            prev_free_q;
	logic [BW-1:0]   prev_p_q;
	logic [SW-1:0]   prev_s_q;

	logic [BW-1:0]   start_q;
	logic [SW-1:0]   tot_q;

	logic [AW-1:0]   wa_q [4];
	logic [SW-1:0]   wd_q [4];
	logic [1:0]      wi_q;
	logic [1:0]      wlast_q;
	status_t         rs_status_q;
	logic [OFFW-1:0] rs_off_q;

	logic [SW:0]     req_sum;
	logic [BW-1:0]   sz_raw, room, s, p_next, rem;
	logic            blk_free, fits, last, hit, past, split, prev_merge, q_ok;
	logic            we_state;

	// decode of the tag word read in the previous cycle
	assign req_sum    = (SW+1)'(request_bytes) + (SW+1)'(7);
	assign sz_raw     = BW'({rd_data[SW-1:3], 3'b000});
	assign room       = BW'(TOTAL_BYTES - 16) - p_q;
	assign s          = (sz_raw > room) ? room : sz_raw;
	assign blk_free   = !rd_data[0];
	assign p_next     = p_q + BW'(16) + s;
	assign last       = (p_next + BW'(16)) > BW'(TOTAL_BYTES);
	assign q_ok       = !last;
	assign fits       = blk_free && (s >= BW'(size_q));
	assign rem        = s - BW'(size_q);
	assign split      = rem >= BW'(16);
	assign hit        = (p_q + BW'(8)) == BW'(off_q);
	assign past       = (p_q + BW'(8)) > BW'(off_q);
	assign prev_merge = have_prev_q && prev_free_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_INIT0: state_d = S_INIT1;
			S_INIT1: state_d = S_IDLE;
			S_IDLE: begin
				if (start) state_d = S_READ;
			end
			S_READ: state_d = S_EVAL;
			S_EVAL: begin
				if (kind_q == KIND_ALLOC) begin
					if (fits)      state_d = S_WRITE;
					else if (last) state_d = S_IDLE;
					else           state_d = S_READ;
				end else begin
					if (hit)               state_d = q_ok ? S_READQ : S_MERGE;
					else if (past || last) state_d = S_IDLE;
					else                   state_d = S_READ;
				end
			end
			S_READQ: state_d = S_EVALQ;
			S_EVALQ: state_d = S_MERGE;
			S_MERGE: state_d = S_WRITE;
			S_WRITE: begin
				if (wi_q == wlast_q) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: memory port, busy and the finished result
	always_comb begin
		busy          = (state_q != S_IDLE);
		mem_req.we    = 1'b0;
		mem_req.addr  = word_idx(p_q);
		mem_req.wdata = wd_q[wi_q];
		res.valid     = 1'b0;
		res.status    = rs_status_q;
		res.offset    = rs_off_q;
		case (state_q)
			S_INIT0: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = '0;
				mem_req.wdata = SW'(DATA_BYTES);
			end
			S_INIT1: begin
				mem_req.we    = 1'b1;
				mem_req.addr  = AW'(DEPTH - 1);
				mem_req.wdata = SW'(DATA_BYTES);
			end
			S_EVAL: begin
				if (kind_q == KIND_ALLOC) begin
					if (!fits && last) begin
						res.valid  = 1'b1;
						res.status = ST_NOFIT;
						res.offset = '0;
					end
				end else if (!hit && (past || last)) begin
					res.valid  = 1'b1;
					res.status = ST_RANGE;
					res.offset = '0;
				end
			end
			S_WRITE: begin
				mem_req.we   = 1'b1;
				mem_req.addr = wa_q[wi_q];
				res.valid    = (wi_q == wlast_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT0;
			p_q         <= '0;
			have_prev_q <= 1'b0;
			wi_q        <= '0;
			wlast_q     <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						p_q         <= '0;
						have_prev_q <= 1'b0;
					end
				end
				S_EVAL: begin
					if (kind_q == KIND_ALLOC) begin
						if (fits) begin
							wi_q <= '0;
							wlast_q <= split ? 2'd3 : 2'd1;
						end else begin
							p_q <= p_next;
						end
					end else if (hit) begin
						// p moves on to the right neighbour for the merge check
						p_q <= p_next;
					end else begin
						have_prev_q <= 1'b1;
						p_q         <= p_next;
					end
				end
				S_MERGE: begin
					wi_q    <= '0;
					wlast_q <= 2'd1;
				end
				S_WRITE: begin
					wi_q <= wi_q + 2'd1;
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					kind_q <= kind;
					size_q <= {req_sum[SW-1:3], 3'b000};
					off_q  <= block_offset;
				end
			end
			S_EVAL: begin
				if (kind_q == KIND_ALLOC) begin
					if (fits) begin
						rs_status_q <= ST_GRANT;
						rs_off_q    <= OFFW'(p_q + BW'(8));
						wa_q[0]     <= word_idx(p_q);
						if (split) begin
							wd_q[0] <= {size_q[SW-1:1], 1'b1};
							wa_q[1] <= word_idx(p_q + BW'(12) + BW'(size_q));
							wd_q[1] <= {size_q[SW-1:1], 1'b1};
							wa_q[2] <= word_idx(p_q + BW'(16) + BW'(size_q));
							wd_q[2] <= SW'(rem - BW'(16));
							wa_q[3] <= word_idx(p_q + BW'(12) + s);
							wd_q[3] <= SW'(rem - BW'(16));
						end else begin
							wd_q[0] <= {s[SW-1:1], 1'b1};
							wa_q[1] <= word_idx(p_q + BW'(12) + s);
							wd_q[1] <= {s[SW-1:1], 1'b1};
						end
					end
				end else if (hit) begin
					tot_q   <= SW'(s) + (prev_merge ? (SW'(16) + prev_s_q) : '0);
					start_q <= prev_merge ? prev_p_q : p_q;
				end else begin
					prev_p_q    <= p_q;
					prev_s_q    <= SW'(s);
					prev_free_q <= blk_free;
				end
			end
			S_EVALQ: begin
				if (blk_free) tot_q <= tot_q + SW'(16) + SW'(s);
			end
			S_MERGE: begin
				rs_status_q <= ST_FREED;
				rs_off_q    <= '0;
				wa_q[0]     <= word_idx(start_q);
				wd_q[0]     <= tot_q;
				wa_q[1]     <= word_idx(start_q + BW'(12) + BW'(tot_q));
				wd_q[1]     <= tot_q;
			end
			default: begin
			end
		endcase
	end

	assign we_state = (state_q == S_WRITE) || (state_q == S_INIT0) || (state_q == S_INIT1);

`include "assert_macros.svh"

	`BTA_ASSERT_IMPL(a_we_in_write, mem_req.we, we_state)
	`BTA_ASSERT(a_p_aligned, p_q[2:0] == 3'd0)
	`BTA_ASSERT_IMPL(a_read_in_heap, state_q == S_READ, (p_q + BW'(16)) <= BW'(TOTAL_BYTES))
	`BTA_ASSERT_NEXT(a_result_then_idle, res.valid, state_q == S_IDLE)

endmodule

>>> design/boundary_tag_heap_allocator.sv
// ---------------------------------------------------------------------------
// boundary_tag_heap_allocator
// first-fit heap allocator with start and end boundary tags
// ---------------------------------------------------------------------------
// A beat is taken when start is high and busy is low; its result appears on
// status and data_offset for one cycle with done high and cannot be held off.
// After reset the block writes the initial whole-heap tags in S_INIT0 and
// S_INIT1 with busy high. The tags sit in one single-port ram, so every block
// visited takes an address state (S_READ), then an evaluate state (S_EVAL).
// An allocate walks the blocks from the start of the heap, then writes 2 tags,
// or 4 when the block is split; no fit ends after the walk. A free walks to
// the block, reads the right neighbour when there is one (S_READQ, S_EVALQ),
// forms the merged size in S_MERGE and writes 2 tags; an offset that is not
// a block ends after the walk. done is registered and rises in the cycle
// after the last of these; the next beat may be taken in that same cycle.
module boundary_tag_heap_allocator (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic                     kind,
	input  logic [bta_pkg::REQW-1:0] request_bytes,
	input  logic [bta_pkg::OFFW-1:0] block_offset,
	output logic                     done,
	output logic [1:0]               status,
	output logic [bta_pkg::OFFW-1:0] data_offset
);
	import bta_pkg::*;

	mem_req_t        mem_req;
	logic [SW-1:0]   rd_data;
	result_t         res;
	logic            done_q;
	status_t         status_q;
	logic [OFFW-1:0] data_offset_q;

	bta_ram #(
		.WIDTH(SW),
		.DEPTH(DEPTH)
	) u_tag_ram (
		.clk  (clk),
		.we   (mem_req.we),
		.addr (mem_req.addr),
		.wdata(mem_req.wdata),
		.rdata(rd_data)
	);

	bta_engine u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.request_bytes(request_bytes),
		.block_offset (block_offset),
		.busy         (busy),
		.mem_req      (mem_req),
		.rd_data      (rd_data),
		.res          (res)
	);

	// result register, one cycle strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q      <= res.status;
			data_offset_q <= res.offset;
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign data_offset = data_offset_q;

endmodule
